[src/pcte_pkg.sv]
// Package: shared types, opcode constants and opcode decode functions for the color table extractor.
package pcte_pkg;

    // Bytes skipped after a pixmap opcode, and the color table entry limit
    localparam int PIXMAP_SKIP = 46;
    localparam int MAX_COLORS  = 256;

    // Picture size plus frame, skipped at the start of a picture
    localparam logic [31:0] HEADER_SKIP = 32'd10;

    // Opcodes with a special meaning
    localparam logic [15:0] OP_LONG_MIN    = 16'h8100;
    localparam logic [15:0] OP_END_PIC     = 16'h00FF;
    localparam logic [15:0] OP_HEADER_OP   = 16'h0C00;
    localparam logic [15:0] OP_BITS_RECT   = 16'h0090;
    localparam logic [15:0] OP_BITS_RGN    = 16'h0091;
    localparam logic [15:0] OP_PACK_RECT   = 16'h0098;
    localparam logic [15:0] OP_PACK_RGN    = 16'h0099;
    localparam logic [15:0] OP_LONG_COMM   = 16'h00A1;
    localparam logic [15:0] OP_SHORT_MIN   = 16'h009A;
    localparam logic [15:0] OP_SHORT_MAX   = 16'h009F;
    localparam logic [15:0] OP_SHORT_COMM  = 16'h00A2;
    localparam logic [15:0] OP_CLIP_RGN    = 16'h0001;
    localparam logic [15:0] OP_RGN_MIN     = 16'h0080;
    localparam logic [15:0] OP_RGN_MAX     = 16'h0084;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
    } pcte_in_t;

    // Result transfer payload
    typedef struct packed {
        logic [7:0] table_byte;
        logic       status;
        logic       is_last;
    } pcte_out_t;

    // Result handed from the parser to the output stage
    typedef struct packed {
        logic      valid;
        pcte_out_t data;
    } pcte_res_t;

    // Region opcodes carry a size that counts its own two bytes
    function automatic logic is_region(input logic [15:0] op);
        return (op == OP_CLIP_RGN) || ((op >= OP_RGN_MIN) && (op <= OP_RGN_MAX));
    endfunction

    // Pixmap opcodes lead to the color table
    function automatic logic is_pixmap(input logic [15:0] op);
        return (op == OP_BITS_RECT) || (op == OP_BITS_RGN) ||
               (op == OP_PACK_RECT) || (op == OP_PACK_RGN);
    endfunction

    // Number of length prefix bytes: 0, 2 or 4
    function automatic logic [2:0] prefix_bytes(input logic [15:0] op);
        logic [2:0] n;
        n = 3'd0;
        if ((op >= OP_LONG_MIN) || (op == OP_LONG_COMM)) begin
            n = 3'd4;
        end else if (((op >= OP_SHORT_MIN) && (op <= OP_SHORT_MAX)) ||
                     (op == OP_SHORT_COMM) || is_region(op)) begin
            n = 3'd2;
        end
        return n;
    endfunction

    // Fixed payload length of opcodes without a length prefix
    function automatic logic [4:0] fixed_length(input logic [15:0] op);
        logic [4:0] n;
        case (op) inside
            16'h0004: begin
                n = 5'd1;
            end
            16'h0003, 16'h0005, 16'h0008, 16'h0011, 16'h000D, 16'h0015, 16'h0016,
            16'h0023, 16'h00A0, 16'h0100, 16'h01FF: begin
                n = 5'd2;
            end
            16'h0006, 16'h0007, 16'h000B, 16'h000C, 16'h000E, 16'h000F, 16'h0021,
            16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E,
            16'h006F, 16'h0200: begin
                n = 5'd4;
            end
            16'h0002, 16'h0009, 16'h000A, 16'h0010, 16'h0020, 16'h0030, 16'h0031,
            16'h0032: begin
                n = 5'd8;
            end
            16'h0012, 16'h0013, 16'h0014: begin
                n = 5'd16;
            end
            OP_HEADER_OP: begin
                n = 5'd24;
            end
            default: begin
                n = 5'd0;
            end
        endcase
        return n;
    endfunction

endpackage

[src/pict_color_table_extractor.sv]
// Top level: picture color table extractor, byte stream in, color table bytes out.
//
//   Port group        Dir  Payload                            Handshake
//   s_valid/s_ready   in   s_data  {data_byte, start_flag}    transfer on valid & ready
//   m_valid/m_ready   out  m_data  {table_byte, status, is_last} transfer on valid & ready
//
// One byte is taken per cycle while s_ready is high; its result, if any, shows on m_data the next cycle.
// The parser state updates in the same cycle the byte transfers, so throughput is one
// byte per clock while m_ready stays high.
// s_ready falls only while a result sits in the output register and m_ready is low.
// aresetn (synchronous, active low) returns the parser to the header skip and empties
// the output register; start_flag on a byte restarts the parser as well.
module pict_color_table_extractor #(
    parameter int PIXMAP_SKIP = pcte_pkg::PIXMAP_SKIP,
    parameter int MAX_COLORS  = pcte_pkg::MAX_COLORS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcte_pkg::pcte_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pcte_pkg::pcte_out_t m_data
);

    pcte_pkg::pcte_res_t res;
    logic                load_ok;
    logic                in_accept;

    assign s_ready   = load_ok;
    assign in_accept = s_valid && load_ok;

    pcte_parser #(
        .PIXMAP_SKIP (PIXMAP_SKIP),
        .MAX_COLORS  (MAX_COLORS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_data   (s_data),
        .res       (res)
    );

    pcte_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .res     (res),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[src/pcte_parser.sv]
// Parser: phase, skip and length state, updated once per accepted byte, with the result it causes.
module pcte_parser #(
    parameter int PIXMAP_SKIP = pcte_pkg::PIXMAP_SKIP,
    parameter int MAX_COLORS  = pcte_pkg::MAX_COLORS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  pcte_pkg::pcte_in_t  in_data,
    output pcte_pkg::pcte_res_t res
);

    localparam logic [2:0] PH_SKIP_OP  = 3'd0;
    localparam logic [2:0] PH_OPCODE   = 3'd1;
    localparam logic [2:0] PH_LENGTH   = 3'd2;
    localparam logic [2:0] PH_SKIP_PIX = 3'd3;
    localparam logic [2:0] PH_HEADER   = 3'd4;
    localparam logic [2:0] PH_ENTRIES  = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;

    localparam logic [7:0]  CNT_MAX   = 8'(MAX_COLORS - 1);
    localparam logic [31:0] PIX_SKIP  = 32'(PIXMAP_SKIP);

    logic [2:0]  phase_reg,  phase_next;
    logic [31:0] skip_reg,   skip_next;
    logic [15:0] opcode_reg, opcode_next;
    logic [2:0]  fbi_reg,    fbi_next;
    logic [31:0] len_reg,    len_next;
    logic [11:0] emit_reg,   emit_next;

    // State seen by this byte, after a restart
    logic [2:0]  cur_phase;
    logic [31:0] cur_skip;
    logic [15:0] cur_opcode;
    logic [2:0]  cur_fbi;
    logic [31:0] cur_len;
    logic [11:0] cur_emit;

    logic [7:0]  b;
    logic [31:0] skip_dec;
    logic [15:0] op_new;
    logic [31:0] len_shift;
    logic [2:0]  fbi_inc;
    logic [31:0] skip_len;
    logic [15:0] hdr_len;
    logic [7:0]  cnt_sat;
    logic [8:0]  cnt_plus;
    logic [11:0] emit_dec;
    logic [31:0] es_n;
    logic [2:0]  es_target;
    logic        es_go;

    // Apply restart, then compute next state and result
    always_comb begin
        b = in_data.data_byte;
        if (in_data.start_flag) begin
            cur_phase  = PH_SKIP_OP;
            cur_skip   = pcte_pkg::HEADER_SKIP;
            cur_opcode = '0;
            cur_fbi    = '0;
            cur_len    = '0;
            cur_emit   = '0;
        end else begin
            cur_phase  = phase_reg;
            cur_skip   = skip_reg;
            cur_opcode = opcode_reg;
            cur_fbi    = fbi_reg;
            cur_len    = len_reg;
            cur_emit   = emit_reg;
        end

        skip_dec  = (cur_skip != '0) ? cur_skip - 32'd1 : '0;
        op_new    = {cur_opcode[7:0], b};
        len_shift = {cur_len[23:0], b};
        fbi_inc   = cur_fbi + 3'd1;
        hdr_len   = {cur_len[7:0], b};
        cnt_sat   = (hdr_len > {8'd0, CNT_MAX}) ? CNT_MAX : hdr_len[7:0];
        cnt_plus  = {1'b0, cnt_sat} + 9'd1;
        emit_dec  = (cur_emit != '0) ? cur_emit - 12'd1 : '0;

        if (pcte_pkg::is_region(cur_opcode)) begin
            skip_len = (len_shift >= 32'd2) ? len_shift - 32'd2 : '0;
        end else begin
            skip_len = len_shift;
        end

        phase_next  = cur_phase;
        skip_next   = cur_skip;
        opcode_next = cur_opcode;
        fbi_next    = cur_fbi;
        len_next    = cur_len;
        emit_next   = cur_emit;

        es_go     = 1'b0;
        es_n      = '0;
        es_target = PH_OPCODE;

        res.valid           = 1'b0;
        res.data.table_byte = '0;
        res.data.status     = 1'b0;
        res.data.is_last    = 1'b0;

        unique case (cur_phase)
            PH_SKIP_OP, PH_SKIP_PIX: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    phase_next = (cur_phase == PH_SKIP_PIX) ? PH_HEADER : PH_OPCODE;
                    fbi_next   = '0;
                    len_next   = '0;
                end
            end
            PH_OPCODE: begin
                opcode_next = op_new;
                if (cur_fbi == '0) begin
                    fbi_next = 3'd1;
                end else begin
                    fbi_next = '0;
                    if (op_new == pcte_pkg::OP_END_PIC) begin
                        phase_next      = PH_DONE;
                        res.valid       = 1'b1;
                        res.data.status = 1'b1;
                        res.data.is_last = 1'b1;
                    end else if (pcte_pkg::is_pixmap(op_new)) begin
                        es_go     = 1'b1;
                        es_n      = PIX_SKIP;
                        es_target = PH_HEADER;
                    end else if (pcte_pkg::prefix_bytes(op_new) != '0) begin
                        phase_next = PH_LENGTH;
                        len_next   = '0;
                    end else begin
                        es_go = 1'b1;
                        es_n  = {27'd0, pcte_pkg::fixed_length(op_new)};
                    end
                end
            end
            PH_LENGTH: begin
                len_next = len_shift;
                fbi_next = fbi_inc;
                if (fbi_inc >= pcte_pkg::prefix_bytes(cur_opcode)) begin
                    es_go = 1'b1;
                    es_n  = skip_len;
                end
            end
            PH_HEADER: begin
                if (cur_fbi >= 3'd6) begin
                    len_next = {16'd0, hdr_len};
                end
                res.valid           = 1'b1;
                res.data.table_byte = b;
                if (cur_fbi == 3'd7) begin
                    emit_next  = {cnt_plus, 3'b000};
                    fbi_next   = '0;
                    phase_next = PH_ENTRIES;
                end else begin
                    fbi_next = fbi_inc;
                end
            end
            PH_ENTRIES: begin
                res.valid           = 1'b1;
                res.data.table_byte = b;
                emit_next           = emit_dec;
                if (emit_dec == '0) begin
                    phase_next       = PH_DONE;
                    res.data.is_last = 1'b1;
                end
            end
            default: begin
                // finished: drop bytes until restart
            end
        endcase

        // Start a skip; an empty skip goes straight to its target
        if (es_go) begin
            skip_next = es_n;
            fbi_next  = '0;
            len_next  = '0;
            if (es_n == '0) begin
                phase_next = es_target;
            end else begin
                phase_next = (es_target == PH_HEADER) ? PH_SKIP_PIX : PH_SKIP_OP;
            end
        end

        res.valid = res.valid & in_accept;
    end

    // Advance state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP_OP;
            skip_reg   <= pcte_pkg::HEADER_SKIP;
            opcode_reg <= '0;
            fbi_reg    <= '0;
            len_reg    <= '0;
            emit_reg   <= '0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            opcode_reg <= opcode_next;
            fbi_reg    <= fbi_next;
            len_reg    <= len_next;
            emit_reg   <= emit_next;
        end
    end

endmodule

[src/pcte_out_reg.sv]
// Output register: holds one result until the downstream side takes it.
module pcte_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  pcte_pkg::pcte_res_t res,
    output logic                load_ok,
    output logic                m_valid,
    input  logic                m_ready,
    output pcte_pkg::pcte_out_t m_data
);

    logic                valid_reg;
    pcte_pkg::pcte_out_t data_reg;

    // Room when empty or when the held result leaves this cycle
    assign load_ok = !valid_reg || m_ready;

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ok) begin
            valid_reg <= res.valid;
        end
    end

    // Load payload with each new result
    always_ff @(posedge aclk) begin
        if (load_ok && res.valid) begin
            data_reg <= res.data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
